[rtl/tpvc_pkg.sv]
// ----------------------------------------------------------------------------
// tpvc_pkg
// Shared types, register indexes and helpers of the parallax view culler.
// ----------------------------------------------------------------------------
package tpvc_pkg;

    // Register index, taken from paddr[4:2]
    localparam logic [2:0] REG_TILE_W  = 3'd0;
    localparam logic [2:0] REG_TILE_H  = 3'd1;
    localparam logic [2:0] REG_VIEW_W  = 3'd2;
    localparam logic [2:0] REG_VIEW_H  = 3'd3;
    localparam logic [2:0] REG_PAR_X   = 3'd4;
    localparam logic [2:0] REG_PAR_Y   = 3'd5;
    localparam logic [2:0] REG_DEPTH   = 3'd6;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    // Map index width that covers the largest map dimension
    localparam int IDX_W = 10;
    // Quotient width of the range division
    localparam int QUO_W = 18;

    localparam logic signed [19:0] SCR_MAX = 20'sd131071;
    localparam logic signed [19:0] SCR_MIN = -20'sd131072;

    typedef struct packed {
        logic [6:0]  tile_width;
        logic [6:0]  tile_height;
        logic [11:0] viewport_width;
        logic [11:0] viewport_height;
        logic [16:0] parallax_x;
        logic [16:0] parallax_y;
        logic [7:0]  layer_depth;
    } t_cfg;

    // Treat a zero tile size as one pixel
    function automatic logic [6:0] eff_tile(input logic [6:0] t);
        eff_tile = (t == 7'd0) ? 7'd1 : t;
    endfunction

    // Tile index times tile size minus offset, saturated to 18 bits signed
    function automatic logic signed [17:0] screen_pos(
        input logic [IDX_W-1:0] idx,
        input logic [6:0]       tile,
        input logic [16:0]      offs
    );
        logic [16:0]        prod;
        logic signed [19:0] v;
        prod = 17'(idx * eff_tile(tile));
        v    = $signed({3'b000, prod}) - $signed({3'b000, offs});
        if (v > SCR_MAX) begin
            screen_pos = 18'(SCR_MAX);
        end else if (v < SCR_MIN) begin
            screen_pos = 18'(SCR_MIN);
        end else begin
            screen_pos = v[17:0];
        end
    endfunction

endpackage

[rtl/tilemap_parallax_view_culler.sv]
// ----------------------------------------------------------------------------
// tilemap_parallax_view_culler
// Tile map layer with parallax scroll and view culling.
//
//   channel   ports                              handshake
//   request   i_kind .. i_viewport_y             start high, busy low
//   result    o_texture_id .. o_truncated        o_valid per tile
//   config    psel penable pwrite paddr pwdata   APB, pready always high
//
// The front is busy after an in-map write until its push, and after a render through
// one multiply, 18 steps of four parallel restoring divider lanes, one clamp and,
// for a non-empty span, one push; a push waits while the two-entry queue is full.
// The back emits one tile per cycle, up to MAX_EMIT, each in the cycle after its
// walk step. The receiver cannot stall. Reset is synchronous; the map has no reset value.
// ----------------------------------------------------------------------------
module tilemap_parallax_view_culler #(
    parameter int MAP_COLS = 128,
    parameter int MAP_ROWS = 128,
    parameter int MAX_EMIT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [6:0]          i_tile_row,
    input  logic [6:0]          i_tile_col,
    input  logic [15:0]         i_tile_texture,
    input  logic [15:0]         i_viewport_x,
    input  logic [15:0]         i_viewport_y,
    output logic                o_valid,
    output logic [15:0]         o_texture_id,
    output logic signed [17:0]  o_screen_x,
    output logic signed [17:0]  o_screen_y,
    output logic [7:0]          o_draw_depth,
    output logic                o_last,
    output logic                o_truncated,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = $clog2(MAP_ROWS * MAP_COLS);
    localparam int CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int QW = 1 + AW + 16 + 2 * CW + 2 * RW + 34;

    tpvc_pkg::t_cfg r_cfg;
    logic           cfg_we;

    logic           f_push, f_kind, q_valid, q_full, q_pop;
    logic [AW-1:0]  f_addr;
    logic [15:0]    f_data;
    logic [CW-1:0]  f_sc, f_ec;
    logic [RW-1:0]  f_sr, f_er;
    logic [16:0]    f_ox, f_oy;
    logic [QW-1:0]  q_in, q_out;

    // Write configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_width      <= 7'd16;
            r_cfg.tile_height     <= 7'd16;
            r_cfg.viewport_width  <= 12'd640;
            r_cfg.viewport_height <= 12'd480;
            r_cfg.parallax_x      <= 17'd65536;
            r_cfg.parallax_y      <= 17'd65536;
            r_cfg.layer_depth     <= 8'd0;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                tpvc_pkg::REG_TILE_W: r_cfg.tile_width      <= pwdata[6:0];
                tpvc_pkg::REG_TILE_H: r_cfg.tile_height     <= pwdata[6:0];
                tpvc_pkg::REG_VIEW_W: r_cfg.viewport_width  <= pwdata[11:0];
                tpvc_pkg::REG_VIEW_H: r_cfg.viewport_height <= pwdata[11:0];
                tpvc_pkg::REG_PAR_X:  r_cfg.parallax_x      <= pwdata[16:0];
                tpvc_pkg::REG_PAR_Y:  r_cfg.parallax_y      <= pwdata[16:0];
                tpvc_pkg::REG_DEPTH:  r_cfg.layer_depth     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (paddr[4:2])
            tpvc_pkg::REG_TILE_W: prdata = 32'(r_cfg.tile_width);
            tpvc_pkg::REG_TILE_H: prdata = 32'(r_cfg.tile_height);
            tpvc_pkg::REG_VIEW_W: prdata = 32'(r_cfg.viewport_width);
            tpvc_pkg::REG_VIEW_H: prdata = 32'(r_cfg.viewport_height);
            tpvc_pkg::REG_PAR_X:  prdata = 32'(r_cfg.parallax_x);
            tpvc_pkg::REG_PAR_Y:  prdata = 32'(r_cfg.parallax_y);
            tpvc_pkg::REG_DEPTH:  prdata = 32'(r_cfg.layer_depth);
            default:              prdata = 32'd0;
        endcase
    end

    tpvc_front #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_tile_row     (i_tile_row),
        .i_tile_col     (i_tile_col),
        .i_tile_texture (i_tile_texture),
        .i_viewport_x   (i_viewport_x),
        .i_viewport_y   (i_viewport_y),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_push         (f_push),
        .o_kind         (f_kind),
        .o_addr         (f_addr),
        .o_data         (f_data),
        .o_sc           (f_sc),
        .o_ec           (f_ec),
        .o_sr           (f_sr),
        .o_er           (f_er),
        .o_ox           (f_ox),
        .o_oy           (f_oy)
    );

    // Pack a classified request for the queue
    assign q_in = {f_kind, f_addr, f_data, f_sc, f_ec, f_sr, f_er, f_ox, f_oy};

    tpvc_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    tpvc_back #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS),
        .MAX_EMIT (MAX_EMIT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_q_pop      (q_pop),
        .i_kind       (q_out[QW-1]),
        .i_addr       (q_out[QW-2 -: AW]),
        .i_data       (q_out[QW-2-AW -: 16]),
        .i_sc         (q_out[QW-18-AW -: CW]),
        .i_ec         (q_out[QW-18-AW-CW -: CW]),
        .i_sr         (q_out[QW-18-AW-2*CW -: RW]),
        .i_er         (q_out[QW-18-AW-2*CW-RW -: RW]),
        .i_ox         (q_out[33:17]),
        .i_oy         (q_out[16:0]),
        .i_cfg        (r_cfg),
        .o_valid      (o_valid),
        .o_texture_id (o_texture_id),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_draw_depth (o_draw_depth),
        .o_last       (o_last),
        .o_truncated  (o_truncated)
    );

endmodule

[rtl/tpvc_ram.sv]
// ----------------------------------------------------------------------------
// tpvc_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/tpvc_fifo.sv]
// ----------------------------------------------------------------------------
// tpvc_fifo
// Short show-ahead queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
module tpvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    // Store a request on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (32'(r_wptr) == DEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (32'(r_rptr) == DEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (32'(r_count) == DEPTH);

endmodule

[rtl/tpvc_front.sv]
// ----------------------------------------------------------------------------
// tpvc_front
// Accepts requests, scales the viewport by the parallax factor and divides
// the covered span by the tile size to get the column and row ranges.
// ----------------------------------------------------------------------------
module tpvc_front #(
    parameter int MAP_COLS = 128,
    parameter int MAP_ROWS = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_kind,
    input  logic [6:0]           i_tile_row,
    input  logic [6:0]           i_tile_col,
    input  logic [15:0]          i_tile_texture,
    input  logic [15:0]          i_viewport_x,
    input  logic [15:0]          i_viewport_y,
    input  tpvc_pkg::t_cfg       i_cfg,
    input  logic                 i_q_full,
    output logic                 o_push,
    output logic                 o_kind,
    output logic [$clog2(MAP_ROWS*MAP_COLS)-1:0] o_addr,
    output logic [15:0]          o_data,
    output logic [((MAP_COLS > 1) ? $clog2(MAP_COLS) : 1)-1:0] o_sc,
    output logic [((MAP_COLS > 1) ? $clog2(MAP_COLS) : 1)-1:0] o_ec,
    output logic [((MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1)-1:0] o_sr,
    output logic [((MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1)-1:0] o_er,
    output logic [16:0]          o_ox,
    output logic [16:0]          o_oy
);

    localparam int AW = $clog2(MAP_ROWS * MAP_COLS);
    localparam int CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int QW = tpvc_pkg::QUO_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic            r_kind;
    logic [AW-1:0]   r_addr;
    logic [15:0]     r_data;
    logic [15:0]     r_vx, r_vy;
    logic [16:0]     r_ox, r_oy;
    logic [QW-1:0]   r_num [4];
    logic [6:0]      r_rem [4];
    logic [4:0]      r_cnt;
    logic [CW-1:0]   r_sc, r_ec;
    logic [RW-1:0]   r_sr, r_er;

    logic [32:0]     prod_x, prod_y;
    logic [6:0]      div_t [4];
    logic [7:0]      trial [4];
    logic            fit [4];
    logic            in_map;
    logic [31:0]     ec32, er32;
    logic            empty;

    // Scale viewport position by the parallax factor
    assign prod_x = 33'(r_vx * i_cfg.parallax_x);
    assign prod_y = 33'(r_vy * i_cfg.parallax_y);

    assign in_map = (32'(i_tile_row) < MAP_ROWS) && (32'(i_tile_col) < MAP_COLS);

    // One restoring division step in each of the four lanes
    always_comb begin
        div_t[0] = tpvc_pkg::eff_tile(i_cfg.tile_width);
        div_t[1] = tpvc_pkg::eff_tile(i_cfg.tile_width);
        div_t[2] = tpvc_pkg::eff_tile(i_cfg.tile_height);
        div_t[3] = tpvc_pkg::eff_tile(i_cfg.tile_height);
        for (int i = 0; i < 4; i++) begin
            trial[i] = {r_rem[i], r_num[i][QW-1]};
            fit[i]   = (trial[i] >= {1'b0, div_t[i]});
        end
    end

    // Clamp the end indexes to the map and detect an empty span
    always_comb begin
        ec32  = (32'(r_num[1]) >= MAP_COLS) ? 32'(MAP_COLS - 1) : 32'(r_num[1]);
        er32  = (32'(r_num[3]) >= MAP_ROWS) ? 32'(MAP_ROWS - 1) : 32'(r_num[3]);
        empty = (32'(r_num[0]) > ec32) || (32'(r_num[2]) > er32);
    end

    // Sequence one request
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_kind == tpvc_pkg::KIND_RENDER) begin
                        n_state = S_MUL;
                    end else if (in_map) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 5'(QW - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = empty ? S_IDLE : S_PUSH;
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and run the datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_kind <= i_kind;
            r_addr <= AW'(32'(i_tile_row) * MAP_COLS + 32'(i_tile_col));
            r_data <= i_tile_texture;
            r_vx   <= i_viewport_x;
            r_vy   <= i_viewport_y;
        end
        if (r_state == S_MUL) begin
            r_ox     <= prod_x[32:16];
            r_oy     <= prod_y[32:16];
            r_num[0] <= {1'b0, prod_x[32:16]};
            r_num[1] <= {1'b0, prod_x[32:16]} + QW'(i_cfg.viewport_width);
            r_num[2] <= {1'b0, prod_y[32:16]};
            r_num[3] <= {1'b0, prod_y[32:16]} + QW'(i_cfg.viewport_height);
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= '0;
            end
            r_cnt <= '0;
        end
        if (r_state == S_DIV) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[i] <= fit[i] ? 7'(trial[i] - {1'b0, div_t[i]}) : trial[i][6:0];
                r_num[i] <= {r_num[i][QW-2:0], fit[i]};
            end
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_FIN) begin
            r_sc <= CW'(r_num[0]);
            r_ec <= CW'(ec32);
            r_sr <= RW'(r_num[2]);
            r_er <= RW'(er32);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_q_full;
    assign o_kind = r_kind;
    assign o_addr = r_addr;
    assign o_data = r_data;
    assign o_sc   = r_sc;
    assign o_ec   = r_ec;
    assign o_sr   = r_sr;
    assign o_er   = r_er;
    assign o_ox   = r_ox;
    assign o_oy   = r_oy;

endmodule

[rtl/tpvc_back.sv]
// ----------------------------------------------------------------------------
// tpvc_back
// Carries out queued requests: stores map entries and walks the visible
// tile range in row-major order, one result per cycle.
// ----------------------------------------------------------------------------
module tpvc_back #(
    parameter int MAP_COLS = 128,
    parameter int MAP_ROWS = 128,
    parameter int MAX_EMIT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  logic                 i_kind,
    input  logic [$clog2(MAP_ROWS*MAP_COLS)-1:0] i_addr,
    input  logic [15:0]          i_data,
    input  logic [((MAP_COLS > 1) ? $clog2(MAP_COLS) : 1)-1:0] i_sc,
    input  logic [((MAP_COLS > 1) ? $clog2(MAP_COLS) : 1)-1:0] i_ec,
    input  logic [((MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1)-1:0] i_sr,
    input  logic [((MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1)-1:0] i_er,
    input  logic [16:0]          i_ox,
    input  logic [16:0]          i_oy,
    input  tpvc_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    output logic [15:0]          o_texture_id,
    output logic signed [17:0]   o_screen_x,
    output logic signed [17:0]   o_screen_y,
    output logic [7:0]           o_draw_depth,
    output logic                 o_last,
    output logic                 o_truncated
);

    localparam int AW = $clog2(MAP_ROWS * MAP_COLS);
    localparam int CW = (MAP_COLS > 1) ? $clog2(MAP_COLS) : 1;
    localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int KW = (MAX_EMIT > 1) ? $clog2(MAX_EMIT) : 1;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [RW-1:0]    r_r, r_er;
    logic [CW-1:0]    r_c, r_sc, r_ec;
    logic [16:0]      r_ox, r_oy;
    logic [KW-1:0]    r_k;
    logic             r_valid, r_last, r_trunc;
    logic signed [17:0] r_sx, r_sy;

    logic             tile_end, k_end, last;
    logic [AW-1:0]    raddr;
    logic             we;

    // Pop a queued request whenever the walker is free
    assign o_q_pop = (r_state == B_IDLE) && i_q_valid;
    assign we      = o_q_pop && (i_kind == tpvc_pkg::KIND_WRITE);

    assign tile_end = (r_r == r_er) && (r_c == r_ec);
    assign k_end    = (32'(r_k) == MAX_EMIT - 1);
    assign last     = tile_end || k_end;
    assign raddr    = AW'(32'(r_r) * MAP_COLS + 32'(r_c));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (o_q_pop && i_kind == tpvc_pkg::KIND_RENDER) begin
                    n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (last) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == B_RUN);
        end
    end

    // Load a span, then advance column then row
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_r  <= i_sr;
            r_er <= i_er;
            r_c  <= i_sc;
            r_sc <= i_sc;
            r_ec <= i_ec;
            r_ox <= i_ox;
            r_oy <= i_oy;
            r_k  <= '0;
        end else if (r_state == B_RUN) begin
            if (r_c == r_ec) begin
                r_c <= r_sc;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
            r_k <= r_k + 1'b1;
        end
        if (r_state == B_RUN) begin
            r_sx    <= tpvc_pkg::screen_pos(tpvc_pkg::IDX_W'(r_c),
                                            i_cfg.tile_width, r_ox);
            r_sy    <= tpvc_pkg::screen_pos(tpvc_pkg::IDX_W'(r_r),
                                            i_cfg.tile_height, r_oy);
            r_last  <= last;
            r_trunc <= k_end && !tile_end;
        end
    end

    tpvc_ram #(
        .WIDTH (16),
        .DEPTH (MAP_ROWS * MAP_COLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_addr),
        .i_wdata (i_data),
        .i_raddr (raddr),
        .o_rdata (o_texture_id)
    );

    assign o_valid      = r_valid;
    assign o_screen_x   = r_sx;
    assign o_screen_y   = r_sy;
    assign o_draw_depth = i_cfg.layer_depth;
    assign o_last       = r_last;
    assign o_truncated  = r_trunc;

endmodule
